// File: src/mrhw_pkg.sv
// ============================================================================
// mrhw_pkg - shared types and constants of the right-hand maze walker
// Command and response word layouts, command kinds, headings, register
// indexes and register reset values.
// ============================================================================
`default_nettype none

package mrhw_pkg;

    // command kinds
    localparam logic [1:0] KIND_TILE    = 2'd0;
    localparam logic [1:0] KIND_RESTART = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    // headings
    localparam logic [1:0] HEAD_UP    = 2'd0;
    localparam logic [1:0] HEAD_LEFT  = 2'd1;
    localparam logic [1:0] HEAD_DOWN  = 2'd2;
    localparam logic [1:0] HEAD_RIGHT = 2'd3;

    // register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_ROW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_ROW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_COL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_DIR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_TICKS = 3'd7;

    // register reset values
    localparam logic [6:0]  RST_GRID_ROWS  = 7'd64;
    localparam logic [6:0]  RST_GRID_COLS  = 7'd64;
    localparam logic [5:0]  RST_ENTRY_ROW  = 6'd1;
    localparam logic [5:0]  RST_ENTRY_COL  = 6'd1;
    localparam logic [5:0]  RST_EXIT_ROW   = 6'd62;
    localparam logic [5:0]  RST_EXIT_COL   = 6'd62;
    localparam logic [1:0]  RST_START_DIR  = HEAD_UP;
    localparam logic [15:0] RST_MOVE_TICKS = 16'd100;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  tile_row;
        logic [5:0]  tile_col;
        logic        tile_free;
        logic [15:0] delta_ticks;
    } cmd_word_t;

    typedef struct packed {
        logic [5:0] pos_row;
        logic [5:0] pos_col;
        logic [1:0] heading;
        logic       moved;
        logic       at_exit;
        logic       stuck;
    } rsp_word_t;

endpackage

`default_nettype wire

// File: src/maze_right_hand_walker_top.sv
// ============================================================================
// maze_right_hand_walker_top - right-hand rule maze walker
// Holds a tile map, paces moves from accumulated ticks and walks the map
// from the entrance to the exit with a right-hand wall follower.
// ============================================================================
//
//  channel | handshake            | word
//  --------+----------------------+--------------------------------------
//  cmd     | cmd_valid/cmd_stall  | mrhw_pkg::cmd_word_t (tile/restart/tick)
//  rsp     | rsp_valid/rsp_stall  | mrhw_pkg::rsp_word_t (one move report)
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
//  Tile write, restart and a tick that completes no move are done in idle.
//  The entrance report goes through the load state only. A real move runs the
//  probe sequencer over the single memory read port: a probe and a check
//  state per probed cell, up to 8 probes, then loads the response register.
//  Reset: the tile memory is cleared by a sweep over its GRID_SIDE*GRID_SIDE
//  entries, one entry a cycle, with cmd stalled; cfg writes are taken.
//  Stalls: a finished move waits in the load state until the response
//  register is free, with cmd stalled; a held response word blocks no commands.
//
`default_nettype none

module maze_right_hand_walker_top #(
    parameter int GRID_SIDE = 64
) (
    input  wire                                 clk,
    input  wire                                 rst_n,

    input  wire                                 cmd_valid,
    output logic                                cmd_stall,
    input  wire mrhw_pkg::cmd_word_t            cmd_word,

    output logic                                rsp_valid,
    input  wire                                 rsp_stall,
    output mrhw_pkg::rsp_word_t                 rsp_word,

    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [mrhw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [mrhw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    // usable side: storage side, never beyond the 6-bit coordinate range
    localparam logic [6:0] SIDE_CAP = 7'((GRID_SIDE < 64) ? GRID_SIDE : 64);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE_R,
        ST_CHECK_R,
        ST_PROBE_F,
        ST_CHECK_F,
        ST_EMIT
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [6:0]  grid_rows_reg;
    logic [6:0]  grid_cols_reg;
    logic [5:0]  entry_row_reg;
    logic [5:0]  entry_col_reg;
    logic [5:0]  exit_row_reg;
    logic [5:0]  exit_col_reg;
    logic [1:0]  start_dir_reg;
    logic [15:0] move_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg  <= mrhw_pkg::RST_GRID_ROWS;
            grid_cols_reg  <= mrhw_pkg::RST_GRID_COLS;
            entry_row_reg  <= mrhw_pkg::RST_ENTRY_ROW;
            entry_col_reg  <= mrhw_pkg::RST_ENTRY_COL;
            exit_row_reg   <= mrhw_pkg::RST_EXIT_ROW;
            exit_col_reg   <= mrhw_pkg::RST_EXIT_COL;
            start_dir_reg  <= mrhw_pkg::RST_START_DIR;
            move_ticks_reg <= mrhw_pkg::RST_MOVE_TICKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mrhw_pkg::REG_GRID_ROWS:  grid_rows_reg  <= cfg_data[6:0];
                mrhw_pkg::REG_GRID_COLS:  grid_cols_reg  <= cfg_data[6:0];
                mrhw_pkg::REG_ENTRY_ROW:  entry_row_reg  <= cfg_data[5:0];
                mrhw_pkg::REG_ENTRY_COL:  entry_col_reg  <= cfg_data[5:0];
                mrhw_pkg::REG_EXIT_ROW:   exit_row_reg   <= cfg_data[5:0];
                mrhw_pkg::REG_EXIT_COL:   exit_col_reg   <= cfg_data[5:0];
                mrhw_pkg::REG_START_DIR:  start_dir_reg  <= cfg_data[1:0];
                mrhw_pkg::REG_MOVE_TICKS: move_ticks_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // control and walker state
    // ------------------------------------------------------------------
    state_t      state_reg;
    logic        clr_active_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [5:0]  walker_row_reg;
    logic [5:0]  walker_col_reg;
    logic [1:0]  heading_reg;
    logic [16:0] tick_sum_reg;
    logic        entrance_shown_reg;
    logic        walk_done_reg;
    logic [1:0]  dec_cnt_reg;
    logic        moved_reg;
    logic        stuck_reg;
    logic [5:0]  probe_row_reg;
    logic [5:0]  probe_col_reg;
    logic        probe_inb_reg;
    logic        rsp_valid_reg;
    mrhw_pkg::rsp_word_t rsp_word_reg;

    logic        cmd_take;
    logic        on_exit;
    logic        rsp_free;
    logic [16:0] tick_sum_next;

    assign cmd_stall = clr_active_reg || (state_reg != ST_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign on_exit   = (walker_row_reg == exit_row_reg) && (walker_col_reg == exit_col_reg);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign tick_sum_next = tick_sum_reg + 17'(cmd_word.delta_ticks);

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // ------------------------------------------------------------------
    // shared probe unit: neighbor of the walker in one heading, with the
    // in-grid test against the clamped grid size
    // ------------------------------------------------------------------
    logic [1:0]  probe_dir;
    logic [7:0]  nb_row;
    logic [7:0]  nb_col;
    logic [6:0]  lim_rows;
    logic [6:0]  lim_cols;
    logic        nb_inb;

    assign lim_rows = (grid_rows_reg < SIDE_CAP) ? grid_rows_reg : SIDE_CAP;
    assign lim_cols = (grid_cols_reg < SIDE_CAP) ? grid_cols_reg : SIDE_CAP;
    // right of heading d is d-1 mod 4
    assign probe_dir = (state_reg == ST_PROBE_R) ? (heading_reg - 2'd1) : heading_reg;

    always_comb
    begin
        nb_row = {2'b00, walker_row_reg};
        nb_col = {2'b00, walker_col_reg};
        unique case (probe_dir)
            mrhw_pkg::HEAD_UP:    nb_row = {2'b00, walker_row_reg} - 8'd1;
            mrhw_pkg::HEAD_LEFT:  nb_col = {2'b00, walker_col_reg} - 8'd1;
            mrhw_pkg::HEAD_DOWN:  nb_row = {2'b00, walker_row_reg} + 8'd1;
            mrhw_pkg::HEAD_RIGHT: nb_col = {2'b00, walker_col_reg} + 8'd1;
            default: ;
        endcase
    end

    // bit 7 marks a step below zero
    assign nb_inb = !nb_row[7] && !nb_col[7]
                 && (nb_row[6:0] < lim_rows) && (nb_col[6:0] < lim_cols);

    // ------------------------------------------------------------------
    // tile memory: one write port (clear sweep or tile write), one read port
    // ------------------------------------------------------------------
    logic          maze_mem [DEPTH];
    logic          rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] tile_addr;
    logic          tile_we;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic          mem_wd;

    assign rd_addr   = AW'(32'(nb_row[5:0]) * 32'(GRID_SIDE) + 32'(nb_col[5:0]));
    assign tile_addr = AW'(32'(cmd_word.tile_row) * 32'(GRID_SIDE) + 32'(cmd_word.tile_col));
    assign tile_we   = cmd_take && (cmd_word.kind == mrhw_pkg::KIND_TILE)
                    && (32'(cmd_word.tile_row) < 32'(GRID_SIDE))
                    && (32'(cmd_word.tile_col) < 32'(GRID_SIDE));
    assign mem_we = clr_active_reg || tile_we;
    assign mem_wa = clr_active_reg ? clr_addr_reg : tile_addr;
    assign mem_wd = clr_active_reg ? 1'b0 : cmd_word.tile_free;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            maze_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= maze_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            clr_active_reg     <= 1'b1;
            clr_addr_reg       <= '0;
            walker_row_reg     <= mrhw_pkg::RST_ENTRY_ROW;
            walker_col_reg     <= mrhw_pkg::RST_ENTRY_COL;
            heading_reg        <= mrhw_pkg::RST_START_DIR;
            tick_sum_reg       <= '0;
            entrance_shown_reg <= 1'b0;
            walk_done_reg      <= 1'b0;
            dec_cnt_reg        <= '0;
            moved_reg          <= 1'b0;
            stuck_reg          <= 1'b0;
            probe_row_reg      <= '0;
            probe_col_reg      <= '0;
            probe_inb_reg      <= 1'b0;
            rsp_valid_reg      <= 1'b0;
            rsp_word_reg       <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_active_reg <= 1'b0;
                end
            end

            // the load state sets valid itself
            if (rsp_valid_reg && !rsp_stall && (state_reg != ST_EMIT))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_take && (cmd_word.kind == mrhw_pkg::KIND_RESTART))
                    begin
                        walker_row_reg     <= entry_row_reg;
                        walker_col_reg     <= entry_col_reg;
                        heading_reg        <= start_dir_reg;
                        tick_sum_reg       <= '0;
                        entrance_shown_reg <= 1'b0;
                        walk_done_reg      <= 1'b0;
                    end
                    else if (cmd_take && (cmd_word.kind == mrhw_pkg::KIND_TICK)
                             && !walk_done_reg)
                    begin
                        if (entrance_shown_reg && on_exit)
                        begin
                            // exit was moved onto the walker
                            walk_done_reg <= 1'b1;
                        end
                        else if (tick_sum_next < 17'(move_ticks_reg))
                        begin
                            tick_sum_reg <= tick_sum_next;
                        end
                        else
                        begin
                            tick_sum_reg <= '0;
                            if (!entrance_shown_reg)
                            begin
                                entrance_shown_reg <= 1'b1;
                                moved_reg          <= 1'b1;
                                stuck_reg          <= 1'b0;
                                state_reg          <= ST_EMIT;
                            end
                            else
                            begin
                                dec_cnt_reg <= '0;
                                state_reg   <= ST_PROBE_R;
                            end
                        end
                    end
                end

                ST_PROBE_R, ST_PROBE_F:
                begin
                    probe_row_reg <= nb_row[5:0];
                    probe_col_reg <= nb_col[5:0];
                    probe_inb_reg <= nb_inb;
                    state_reg     <= (state_reg == ST_PROBE_R) ? ST_CHECK_R : ST_CHECK_F;
                end

                ST_CHECK_R:
                begin
                    if (probe_inb_reg && rd_data_reg)
                    begin
                        heading_reg    <= heading_reg - 2'd1;
                        walker_row_reg <= probe_row_reg;
                        walker_col_reg <= probe_col_reg;
                        moved_reg      <= 1'b1;
                        stuck_reg      <= 1'b0;
                        state_reg      <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_PROBE_F;
                    end
                end

                ST_CHECK_F:
                begin
                    if (probe_inb_reg && rd_data_reg)
                    begin
                        walker_row_reg <= probe_row_reg;
                        walker_col_reg <= probe_col_reg;
                        moved_reg      <= 1'b1;
                        stuck_reg      <= 1'b0;
                        state_reg      <= ST_EMIT;
                    end
                    else
                    begin
                        // turn left; four turns bring the heading back
                        heading_reg <= heading_reg + 2'd1;
                        if (dec_cnt_reg == 2'd3)
                        begin
                            moved_reg <= 1'b0;
                            stuck_reg <= 1'b1;
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            dec_cnt_reg <= dec_cnt_reg + 2'd1;
                            state_reg   <= ST_PROBE_R;
                        end
                    end
                end

                ST_EMIT:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg         <= 1'b1;
                        rsp_word_reg.pos_row  <= walker_row_reg;
                        rsp_word_reg.pos_col  <= walker_col_reg;
                        rsp_word_reg.heading  <= heading_reg;
                        rsp_word_reg.moved    <= moved_reg;
                        rsp_word_reg.at_exit  <= on_exit;
                        rsp_word_reg.stuck    <= stuck_reg;
                        if (moved_reg && on_exit)
                        begin
                            walk_done_reg <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // a report never claims both a step and a boxed-in walker
    a_moved_xor_stuck: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_word.moved && rsp_word.stuck))
        else $error("response flags both moved and stuck");

    // the walk can only finish after the entrance was reported
    a_done_after_entry: assert property (@(posedge clk) disable iff (!rst_n)
        walk_done_reg |-> entrance_shown_reg)
        else $error("walk done before entrance report");

    // a move that lands on the exit ends the walk
    a_exit_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && rsp_free && moved_reg && on_exit) |=> walk_done_reg)
        else $error("move onto exit did not end the walk");

    // the clear sweep runs once after reset and never restarts
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_active_reg |=> !clr_active_reg)
        else $error("clear sweep restarted");

    // the right probe state is followed by its check state in the next cycle
    a_probe_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE_R) |=> (state_reg == ST_CHECK_R))
        else $error("probe not followed by check");
`endif

endmodule

`default_nettype wire
